### src/sha256_byte_stream_hasher_defines.svh
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH

`define SBH_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbh assertion failed");

`define SBH_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbh assertion failed");

`else

`define SBH_ASSERT_IMPL(name, ante, cons)

`define SBH_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### src/sbh_pkg.sv
// types, constants and round functions for the sha-256 byte stream hasher
package sbh_pkg;

   typedef enum logic [1:0] {
      CMD_ABSORB = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_START  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_LENW,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### src/sha256_byte_stream_hasher.sv
// sha-256 byte stream hasher: byte buffer, one-round-per-cycle compression, digest output
// an absorbed byte is written into the block buffer; the byte that completes a block starts
// the compression (64 rounds through the single round unit, then the hash update)
// finish compresses one block, or two when padding spills into a second block, then
// eight digest transfers leave through an output register, one per cycle at best
// synchronous reset loads the initial hash values and clears buffer and counters
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sbh_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sbh_pkg::rsp_type rsp_data
);

   sbh_pkg::state_type state_ff, state_in;

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] wk_ff [8];
   logic [31:0] wk_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;
   logic        lenp_ff, lenp_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sbh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        req_xfer;
   logic        emit_load;
   logic [4:0]  byte_sel;
   logic [63:0] bit_len;
   logic [31:0] t1, t2, sched_new;

   // round unit and schedule expansion
   always_comb begin
      t1 = wk_ff[7] + sbh_pkg::big_sigma1(wk_ff[4])
         + ((wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]))
         + sbh_pkg::ROUND_K[rnd_ff] + win_ff[0];
      t2 = sbh_pkg::big_sigma0(wk_ff[0])
         + ((wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]));
      sched_new = win_ff[0] + sbh_pkg::small_sigma0(win_ff[1]) + win_ff[9]
         + sbh_pkg::small_sigma1(win_ff[14]);
   end

   assign byte_sel = {~fill_ff[1:0], 3'b000};
   assign bit_len = {cnt_ff, 3'b000};

   // outputs of the sequencer
   always_comb begin
      req_ready = (state_ff == sbh_pkg::ST_IDLE);
      emit_load = (state_ff == sbh_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_xfer = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbh_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.cmd == sbh_pkg::CMD_ABSORB && fill_ff == sbh_pkg::LAST_BYTE) begin
                  state_in = sbh_pkg::ST_ROUND;
               end else if (req_data.cmd == sbh_pkg::CMD_FINISH) begin
                  state_in = (fill_ff >= sbh_pkg::LEN_OFFSET) ? sbh_pkg::ST_ROUND
                                                             : sbh_pkg::ST_LENW;
               end
            end
         end
         sbh_pkg::ST_ROUND: begin
            if (rnd_ff == sbh_pkg::LAST_ROUND) begin
               state_in = sbh_pkg::ST_UPDATE;
            end
         end
         sbh_pkg::ST_UPDATE: begin
            if (lenp_ff) begin
               state_in = sbh_pkg::ST_LENW;
            end else if (fin_ff) begin
               state_in = sbh_pkg::ST_EMIT;
            end else begin
               state_in = sbh_pkg::ST_IDLE;
            end
         end
         sbh_pkg::ST_LENW: begin
            state_in = sbh_pkg::ST_ROUND;
         end
         sbh_pkg::ST_EMIT: begin
            if (emit_load && idx_ff == sbh_pkg::LAST_WORD) begin
               state_in = sbh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbh_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      hash_in = hash_ff;
      wk_in = wk_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      lenp_in = lenp_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         sbh_pkg::ST_IDLE: begin
            wk_in = hash_ff;
            if (req_xfer) begin
               case (req_data.cmd)
                  sbh_pkg::CMD_ABSORB: begin
                     win_in[fill_ff[5:2]][byte_sel +: 8] = req_data.data_byte;
                     fill_in = fill_ff + 6'd1;
                     cnt_in = cnt_ff + 61'd1;
                  end
                  sbh_pkg::CMD_FINISH: begin
                     win_in[fill_ff[5:2]][byte_sel +: 8] = sbh_pkg::PAD_MARK;
                     fin_in = 1'b1;
                     lenp_in = (fill_ff >= sbh_pkg::LEN_OFFSET);
                  end
                  sbh_pkg::CMD_START: begin
                     hash_in = sbh_pkg::INIT_HASH;
                     for (int i = 0; i < 16; i++) begin
                        win_in[i] = '0;
                     end
                     fill_in = '0;
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sbh_pkg::ST_ROUND: begin
            wk_in[0] = t1 + t2;
            wk_in[1] = wk_ff[0];
            wk_in[2] = wk_ff[1];
            wk_in[3] = wk_ff[2];
            wk_in[4] = wk_ff[3] + t1;
            wk_in[5] = wk_ff[4];
            wk_in[6] = wk_ff[5];
            wk_in[7] = wk_ff[6];
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = sched_new;
            rnd_in = rnd_ff + 6'd1;
         end
         sbh_pkg::ST_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + wk_ff[i];
            end
            for (int i = 0; i < 16; i++) begin
               win_in[i] = '0;
            end
            fill_in = '0;
            lenp_in = 1'b0;
         end
         sbh_pkg::ST_LENW: begin
            wk_in = hash_ff;
            win_in[14] = bit_len[63:32];
            win_in[15] = bit_len[31:0];
            cnt_in = '0;
         end
         sbh_pkg::ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.digest_word = hash_ff[idx_ff];
               rsp_data_in.word_index = idx_ff;
               rsp_data_in.last = (idx_ff == sbh_pkg::LAST_WORD);
               idx_in = idx_ff + 3'd1;
               if (idx_ff == sbh_pkg::LAST_WORD) begin
                  fin_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbh_pkg::ST_IDLE;
         hash_ff <= sbh_pkg::INIT_HASH;
         for (int i = 0; i < 16; i++) begin
            win_ff[i] <= '0;
         end
         fill_ff <= '0;
         cnt_ff <= '0;
         rnd_ff <= '0;
         fin_ff <= 1'b0;
         lenp_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         win_ff <= win_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         rnd_ff <= rnd_in;
         fin_ff <= fin_in;
         lenp_ff <= lenp_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff <= wk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `SBH_ASSERT_IMPL(a_rnd_only_in_round, rnd_ff != 6'd0, state_ff == sbh_pkg::ST_ROUND)
   `SBH_ASSERT_IMPL(a_lenw_short_path, state_ff == sbh_pkg::ST_LENW, fin_ff && !lenp_ff)
   `SBH_ASSERT_NEXT(a_update_clears_fill, state_ff == sbh_pkg::ST_UPDATE, fill_ff == 6'd0)
   `SBH_ASSERT_IMPL(a_emit_after_finish, state_ff == sbh_pkg::ST_EMIT, fin_ff && fill_ff == 6'd0)

endmodule

### test/sha256_byte_stream_hasher_tb.sv
// testbench for the sha-256 byte stream hasher: random message streams checked against a digest predictor
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int LEN_POS = 56;
   localparam int RANDOM_ITEMS = 210;
   localparam int READY_ALWAYS = 0;
   localparam int READY_COIN = 1;
   localparam int READY_SPARSE = 2;
   localparam int READY_TOGGLE = 3;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sbh_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sbh_pkg::rsp_type rsp_data;

   sbh_pkg::req_type pending_reqs[$];
   sbh_pkg::rsp_type digests_due[$];
   sbh_pkg::rsp_type due_word;

   logic [31:0] chain_h [8];
   logic [7:0] blk [64];
   int fill;
   logic [60:0] msg_count;

   int counted_items = 0;
   int error_count = 0;
   int burst_left = 0;
   int idle_left = 0;
   int stall_left = 0;
   int stall_style = READY_ALWAYS;

   sha256_byte_stream_hasher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i - 16] + (rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3))
              + w[i - 7] + (rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10));
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] v);
      blk[fill] = v;
      fill = fill + 1;
      if (fill == 64) compress_block();
   endfunction

   function automatic void restart_chain();
      foreach (chain_h[i]) chain_h[i] = SHA_IV[i];
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      msg_count = '0;
   endfunction

   function automatic void apply_request(input sbh_pkg::req_type r);
      logic [63:0] bit_len;
      sbh_pkg::rsp_type word;
      case (r.cmd)
         sbh_pkg::CMD_ABSORB: begin
            absorb_byte(r.data_byte);
            msg_count = msg_count + 1'b1;
         end
         sbh_pkg::CMD_START: begin
            restart_chain();
         end
         sbh_pkg::CMD_FINISH: begin
            bit_len = {msg_count, 3'b000};
            msg_count = '0;
            absorb_byte(PAD_BYTE);
            if (fill > LEN_POS) compress_block();
            for (int i = 0; i < 8; i++) blk[LEN_POS + i] = bit_len[63 - 8 * i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
               word.digest_word = chain_h[i];
               word.word_index = i[2:0];
               word.last = (i == 7);
               digests_due.push_back(word);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] b);
      sbh_pkg::req_type r;
      r.cmd = cmd;
      r.data_byte = b;
      pending_reqs.push_back(r);
      if (cmd != CMD_UNUSED) counted_items++;
   endtask

   function automatic int pick_length();
      int sel;
      int edges [4] = '{55, 56, 63, 64};
      sel = $urandom_range(0, 15);
      if (sel < 10) return $urandom_range(0, 12);
      if (sel < 13) return edges[$urandom_range(0, 3)];
      if (sel < 15) return $urandom_range(13, 70);
      return $urandom_range(119, 129);
   endfunction

   task automatic queue_message(input bit restart);
      int len;
      len = pick_length();
      if (restart) queue_item(sbh_pkg::CMD_START, 8'($urandom()));
      repeat (len) queue_item(sbh_pkg::CMD_ABSORB, 8'($urandom()));
      queue_item(sbh_pkg::CMD_FINISH, 8'($urandom()));
   endtask

   initial begin
      int kind;
      // empty message straight out of reset, then ignored and chained cases
      queue_item(sbh_pkg::CMD_FINISH, 8'h00);
      queue_item(CMD_UNUSED, 8'hff);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h00);
      queue_item(sbh_pkg::CMD_ABSORB, 8'hff);
      queue_item(sbh_pkg::CMD_ABSORB, 8'ha5);
      queue_item(sbh_pkg::CMD_FINISH, 8'hff);
      queue_item(sbh_pkg::CMD_FINISH, 8'h00);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h5a);
      queue_item(sbh_pkg::CMD_FINISH, 8'h5a);
      queue_item(sbh_pkg::CMD_START, 8'hff);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h61);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h62);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h63);
      queue_item(sbh_pkg::CMD_FINISH, 8'h00);
      queue_item(sbh_pkg::CMD_START, 8'h00);
      queue_item(sbh_pkg::CMD_ABSORB, 8'h80);
      queue_item(sbh_pkg::CMD_START, 8'h00);
      queue_item(CMD_UNUSED, 8'h00);
      queue_item(sbh_pkg::CMD_FINISH, 8'h00);
      counted_items = 0;

      while (counted_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            queue_message(1'b1);
         end else if (kind == 6) begin
            // chain onto the previous digest without a restart
            queue_message(1'b0);
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 4))
               queue_item(2'($urandom_range(0, 3)), 8'($urandom()));
         end else if (kind == 8) begin
            // abandoned message
            queue_item(sbh_pkg::CMD_START, 8'($urandom()));
            repeat ($urandom_range(1, 20)) queue_item(sbh_pkg::CMD_ABSORB, 8'($urandom()));
         end else begin
            queue_item(sbh_pkg::CMD_FINISH, 8'($urandom()));
            queue_item(sbh_pkg::CMD_FINISH, 8'($urandom()));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (digests_due.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS sha256_byte_stream_hasher");
      end else begin
         $display("FAIL sha256_byte_stream_hasher");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL sha256_byte_stream_hasher");
      $finish;
   end

   // request driver: bursts separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (idle_left > 0) begin
            idle_left = idle_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(0, 31);
               idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_style = $urandom_range(READY_ALWAYS, READY_TOGGLE);
            stall_left = $urandom_range(16, 96);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_style)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
            default:      rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // monitor: check digest transfers, then update the predictor
   always @(posedge clock) begin
      if (reset) begin
         restart_chain();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digests_due.size() == 0) begin
               $error("digest transfer with no digest word pending: %h", rsp_data);
               error_count++;
            end else begin
               due_word = digests_due.pop_front();
               if (rsp_data.digest_word !== due_word.digest_word) begin
                  $error("digest_word: expected %h, got %h",
                         due_word.digest_word, rsp_data.digest_word);
                  error_count++;
               end
               if (rsp_data.word_index !== due_word.word_index) begin
                  $error("word_index: expected %0d, got %0d",
                         due_word.word_index, rsp_data.word_index);
                  error_count++;
               end
               if (rsp_data.last !== due_word.last) begin
                  $error("last: expected %b, got %b", due_word.last, rsp_data.last);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_data);
      end
   end

endmodule

### filelist.f
+incdir+src
src/sbh_pkg.sv
src/sha256_byte_stream_hasher.sv
test/sha256_byte_stream_hasher_tb.sv
